// ===== rtl/gwmf_pkg.sv =====
// ---------------------------------------------------------------------------
// gwmf_pkg
// Types and constants of the grayscale window minimum filter.
// ---------------------------------------------------------------------------
package gwmf_pkg;

   localparam int PIX_W      = 8;
   localparam int ROW_W      = 12;
   localparam int COL_OUT_W  = 10;
   localparam int WID_W      = 11;
   localparam int HGT_W      = 13;
   localparam int RAD_W      = 3;
   localparam int SPAN_W     = 4;
   localparam int CSR_DATA_W = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CNT_W      = 6;
   localparam int TREE_N     = 16;

   localparam logic [HGT_W-1:0] HEIGHT_CAP = 13'd4096;
   localparam logic [CNT_W-1:0] CNT_LAST   = 6'd63;
   localparam logic [PIX_W-1:0] PIX_FULL   = 8'hFF;

   localparam logic [WID_W-1:0] WIDTH_RST  = 11'd640;
   localparam logic [HGT_W-1:0] HEIGHT_RST = 13'd480;
   localparam logic [RAD_W-1:0] RADIUS_RST = 3'd1;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KERNEL_RADIUS = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_MIN,
      S_EMIT,
      S_SYNC
   } state_type;

   typedef logic [TREE_N-1:0][PIX_W-1:0] pix_vec_type;

   // pairwise minimum tree, four levels
   function automatic logic [PIX_W-1:0] min_tree(input pix_vec_type v);
      pix_vec_type t;
      t = v;
      for (int lvl = TREE_N / 2; lvl >= 1; lvl = lvl / 2) begin
         for (int i = 0; i < lvl; i++) begin
            t[i] = (t[2*i] < t[2*i+1]) ? t[2*i] : t[2*i+1];
         end
      end
      return t[0];
   endfunction

endpackage

// ===== rtl/grayscale_window_min_filter.sv =====
// ---------------------------------------------------------------------------
// grayscale_window_min_filter
// Streaming square-kernel minimum filter (grayscale erosion) with border
// replication.
// ---------------------------------------------------------------------------
// Pixels arrive in raster order, one per req transaction. The line store word
// of the pixel's column is read in the accept cycle; the next cycle does the
// read-modify-write of that word plus the column-minimum shift, during which
// no new pixel is taken. A pixel that causes results then passes through
// the window-minimum state and gives one result per cycle unless rsp_ready
// stalls; the next pixel is taken in the cycle of the last result. A pixel
// causes zero or one result inside the frame, up to (R+1)^2 at corners,
// capped at 64. The line store is one memory, MAX_WIDTH words deep, each
// word holding the 2*MAX_RADIUS stored rows of one column, so one read and
// one write per pixel. After a configuration write, req_ready stays low
// while the line-store row pointer is recomputed from the row position.
// Frames of 2R rows or 2R columns or fewer give no results.
module grayscale_window_min_filter
   import gwmf_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_RADIUS = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [PIX_W-1:0]      req_pixel,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [ROW_W-1:0]      rsp_out_row,
   output logic [COL_OUT_W-1:0]  rsp_out_column,
   output logic [PIX_W-1:0]      rsp_min_value,
   output logic                  rsp_last_of_run,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int LANES = 2 * MAX_RADIUS;
   localparam int TAPS  = 2 * MAX_RADIUS + 1;
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int EWW   = $clog2(MAX_WIDTH + 1);
   localparam int XW    = (EWW > WID_W) ? EWW : WID_W;
   localparam int LW    = (LANES > 1) ? $clog2(LANES) : 1;

   // configuration
   logic [WID_W-1:0] width_ff;
   logic [HGT_W-1:0] height_ff;
   logic [RAD_W-1:0] radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
         radius_ff <= RADIUS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:   width_ff  <= csr_wdata[WID_W-1:0];
            REG_IMAGE_HEIGHT:  height_ff <= csr_wdata[HGT_W-1:0];
            REG_KERNEL_RADIUS: radius_ff <= csr_wdata[RAD_W-1:0];
            default: ;
         endcase
      end
   end

   logic [XW-1:0]     eff_w;
   logic [HGT_W-1:0]  eff_h;
   logic [RAD_W-1:0]  rad;
   logic [SPAN_W-1:0] span;

   always_comb begin
      if (width_ff == '0) eff_w = XW'(1);
      else if (XW'(width_ff) > XW'(MAX_WIDTH)) eff_w = XW'(MAX_WIDTH);
      else eff_w = XW'(width_ff);
      if (height_ff == '0) eff_h = HGT_W'(1);
      else if (height_ff > HEIGHT_CAP) eff_h = HEIGHT_CAP;
      else eff_h = height_ff;
      rad  = (radius_ff > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_ff;
      span = {rad, 1'b0};
   end

   // line store: one word per column, one byte lane per stored row
   logic [LANES-1:0][PIX_W-1:0] line_mem [MAX_WIDTH];
   logic [LANES-1:0][PIX_W-1:0] rdata_ff;
   logic [LANES-1:0][PIX_W-1:0] wdata;
   logic                        mem_we;

   // position and pipeline state
   state_type         state_ff, state_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [CW-1:0]     col_ff, col_in;
   logic [LW-1:0]     lane_ff, lane_in;
   logic [PIX_W-1:0]  pixel_ff, pixel_in;
   logic [TAPS-1:0][PIX_W-1:0] taps_ff, taps_in;
   logic [PIX_W-1:0]  m_ff, m_in;
   logic [ROW_W-1:0]  ycur_ff, ycur_in, yhi_ff, yhi_in;
   logic [CW-1:0]     xcur_ff, xcur_in, xlo_ff, xlo_in, xhi_ff, xhi_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              sync_pend_ff, sync_pend_in;
   logic [3:0]        sbit_ff, sbit_in;
   logic [SPAN_W:0]   rem_ff, rem_in;

   always_ff @(posedge clock) begin
      rdata_ff <= line_mem[col_ff];
      if (mem_we) line_mem[col_ff] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         lane_ff      <= '0;
         taps_ff      <= {TAPS{PIX_FULL}};
         cnt_ff       <= '0;
         sync_pend_ff <= 1'b0;
         sbit_ff      <= '0;
         rem_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         lane_ff      <= lane_in;
         taps_ff      <= taps_in;
         cnt_ff       <= cnt_in;
         sync_pend_ff <= sync_pend_in;
         sbit_ff      <= sbit_in;
         rem_ff       <= rem_in;
      end
      pixel_ff <= pixel_in;
      m_ff     <= m_in;
      ycur_ff  <= ycur_in;
      yhi_ff   <= yhi_in;
      xcur_ff  <= xcur_in;
      xlo_ff   <= xlo_in;
      xhi_ff   <= xhi_in;
   end

   logic            accept;
   logic            rsp_last;
   logic            emit;
   pix_vec_type     lane_vec, tap_vec;
   logic [PIX_W-1:0] lane_min, vmin;
   logic [XW-1:0]   col_next;
   logic [HGT_W-1:0] row_next;
   logic [ROW_W-1:0] y_ctr;
   logic [CW-1:0]   x_ctr;
   logic [SPAN_W:0] rem_t;

   assign rsp_last = ((ycur_ff == yhi_ff) && (xcur_ff == xhi_ff)) || (cnt_ff == CNT_LAST);
   assign rsp_valid       = (state_ff == S_EMIT);
   assign rsp_out_row     = ycur_ff;
   assign rsp_out_column  = COL_OUT_W'(xcur_ff);
   assign rsp_min_value   = m_ff;
   assign rsp_last_of_run = rsp_last;

   assign req_ready = !sync_pend_ff &&
                      ((state_ff == S_IDLE) ||
                       ((state_ff == S_EMIT) && rsp_ready && rsp_last));
   assign accept    = req_valid && req_ready;

   always_comb begin
      for (int i = 0; i < TREE_N; i++) begin
         lane_vec[i] = PIX_FULL;
         tap_vec[i]  = PIX_FULL;
         if (i < LANES && (SPAN_W'(i) < span) && (ROW_W'(span) <= row_ff))
            lane_vec[i] = rdata_ff[i];
         if (i < TAPS && (SPAN_W'(i) <= span))
            tap_vec[i] = taps_ff[i];
      end
      lane_min = min_tree(lane_vec);
      vmin     = (lane_min < pixel_ff) ? lane_min : pixel_ff;
      wdata    = rdata_ff;
      wdata[lane_ff] = pixel_ff;

      emit = (ROW_W'(span) <= row_ff) && (CW'(span) <= col_ff) &&
             (HGT_W'(row_ff) < eff_h) && (XW'(col_ff) < eff_w);
      y_ctr    = row_ff - ROW_W'(rad);
      x_ctr    = col_ff - CW'(rad);
      col_next = XW'(col_ff) + XW'(1);
      row_next = HGT_W'(row_ff) + HGT_W'(1);
      rem_t    = {rem_ff[SPAN_W-1:0], row_ff[sbit_ff]};
      if (rem_t >= {1'b0, span}) rem_t = rem_t - {1'b0, span};

      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      lane_in      = lane_ff;
      pixel_in     = pixel_ff;
      taps_in      = taps_ff;
      m_in         = m_ff;
      ycur_in      = ycur_ff;
      yhi_in       = yhi_ff;
      xcur_in      = xcur_ff;
      xlo_in       = xlo_ff;
      xhi_in       = xhi_ff;
      cnt_in       = cnt_ff;
      sync_pend_in = sync_pend_ff || csr_we;
      sbit_in      = sbit_ff;
      rem_in       = rem_ff;
      mem_we       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (sync_pend_ff) begin
               state_in = S_SYNC;
               sbit_in  = 4'(ROW_W - 1);
               rem_in   = '0;
            end
         end
         S_READ: begin
            mem_we  = (span != '0);
            taps_in = {taps_ff[TAPS-2:0], vmin};
            ycur_in = (ROW_W'(span) == row_ff) ? '0 : y_ctr;
            yhi_in  = (HGT_W'(row_ff) == eff_h - HGT_W'(1)) ?
                      ROW_W'(eff_h - HGT_W'(1)) : y_ctr;
            xcur_in = (CW'(span) == col_ff) ? '0 : x_ctr;
            xlo_in  = (CW'(span) == col_ff) ? '0 : x_ctr;
            xhi_in  = (XW'(col_ff) == eff_w - XW'(1)) ? CW'(eff_w - XW'(1)) : x_ctr;
            cnt_in  = '0;
            state_in = emit ? S_MIN : S_IDLE;
            // advance raster position
            if (col_next >= eff_w) begin
               col_in = '0;
               if (row_next >= eff_h) begin
                  row_in  = '0;
                  lane_in = '0;
               end else begin
                  row_in  = ROW_W'(row_next);
                  lane_in = ((SPAN_W'(lane_ff) + SPAN_W'(1)) >= span) ?
                            '0 : lane_ff + LW'(1);
               end
            end else begin
               col_in = CW'(col_next);
            end
         end
         S_MIN: begin
            m_in     = min_tree(tap_vec);
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_ready) begin
               cnt_in = cnt_ff + CNT_W'(1);
               if (rsp_last) begin
                  state_in = S_IDLE;
               end else if (xcur_ff == xhi_ff) begin
                  xcur_in = xlo_ff;
                  ycur_in = ycur_ff + ROW_W'(1);
               end else begin
                  xcur_in = xcur_ff + CW'(1);
               end
            end
         end
         S_SYNC: begin
            // restoring remainder: lane pointer = row mod span
            rem_in  = rem_t;
            sbit_in = sbit_ff - 4'd1;
            if (sbit_ff == '0) begin
               lane_in      = (span == '0) ? '0 : LW'(rem_t);
               sync_pend_in = csr_we;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (accept) begin
         pixel_in = req_pixel;
         state_in = S_READ;
      end
   end

   ap_accept_read: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_READ))
      else $error("accepted pixel did not enter line store read");

   ap_burst_cap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (cnt_ff == CNT_LAST)) |-> rsp_last_of_run)
      else $error("result burst exceeded cap without last marker");

   ap_lane_range: assert property (@(posedge clock) disable iff (reset)
      (!sync_pend_ff && (state_ff != S_SYNC) && (span != '0)) |->
      (SPAN_W'(lane_ff) < span))
      else $error("line store row pointer out of range");

   ap_no_accept_sync: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SYNC) |-> !req_ready)
      else $error("input taken during row pointer recompute");

endmodule
